>>> rtl/core/pmul_pkg.sv
`default_nettype none

package pmul_pkg;

    localparam int COEF_W = 32;
    localparam int ACC_W  = 64;
    localparam int DEG_W  = 5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef enum logic {
        OP_STEP,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic x_clear;
        logic prod_en;
        logic acc_step;
        logic flush_shift;
        logic ps_clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/pmul_cell.sv
`default_nettype none

module pmul_cell (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pmul_pkg::t_cell_ctl                      i_ctl,
    input  logic                                     i_load,
    input  logic signed [pmul_pkg::COEF_W-1:0]       i_coef,
    input  logic signed [pmul_pkg::ACC_W-1:0]        i_nb_sum,
    input  logic signed [pmul_pkg::ACC_W-1:0]        i_nb_ps,
    output logic signed [pmul_pkg::ACC_W-1:0]        o_sum,
    output logic signed [pmul_pkg::ACC_W-1:0]        o_ps
);

    import pmul_pkg::*;

    logic signed [COEF_W-1:0] r_x;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_ps;
    logic signed [ACC_W:0]    wide;

    // saturating accumulate
    always_comb begin
        wide = {r_ps[ACC_W-1], r_ps} + {r_prod[ACC_W-1], r_prod};
        if (wide[ACC_W] != wide[ACC_W-1]) begin
            o_sum = wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            o_sum = wide[ACC_W-1:0];
        end
    end

    assign o_ps = r_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (i_load) begin
            r_x <= i_coef;
        end else if (i_ctl.x_clear) begin
            r_x <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= ACC_W'(r_x * i_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= '0;
        end else if (i_ctl.ps_clear) begin
            r_ps <= '0;
        end else if (i_ctl.acc_step) begin
            r_ps <= i_nb_sum;
        end else if (i_ctl.flush_shift) begin
            r_ps <= i_nb_ps;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/polynomial_multiply_top.sv
// a result word passes the input stage, accumulate stage and output register
// throughput: one word per cycle when not stalled; a closing second-operand word
// flushes len_x-1 more coefficients through the cell chain, one per unstalled cycle
// the rate is set by the single accumulate stage each cell runs per cycle
// reset (synchronous, active low) clears the coefficient cells, sums and control
`default_nettype none

module polynomial_multiply_top #(
    parameter int MAX_TERMS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_kind,
    input  logic signed [pmul_pkg::COEF_W-1:0]   i_coef,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [pmul_pkg::ACC_W-1:0]    o_prod_coef,
    output logic [pmul_pkg::DEG_W-1:0]           o_degree,
    output logic                                 o_last_res
);

    import pmul_pkg::*;

    localparam int LEN_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = $clog2(MAX_TERMS);

    // input stage
    logic                    r_v1;
    logic                    r_kind1;
    logic signed [COEF_W-1:0] r_coef1;
    logic                    r_last1;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        n_len;
    logic                    r_closed;
    logic                    n_closed;

    // accumulate stage
    logic                    r_v2;
    t_op                     r_op2;
    logic                    r_last2;
    logic [LEN_W-1:0]        r_n2;
    t_state                  r_state;
    t_state                  n_state;
    logic [LEN_W-1:0]        r_count;
    logic [LEN_W-1:0]        n_count;
    logic [LEN_W-1:0]        r_rem;
    logic [LEN_W-1:0]        n_rem;
    logic [DEG_W-1:0]        r_deg;
    logic [DEG_W-1:0]        n_deg;
    logic [LEN_W-1:0]        cnt_after;

    // output register
    logic                    r_ov;
    logic signed [ACC_W-1:0] r_oprod;
    logic [DEG_W-1:0]        r_odeg;
    logic                    r_olast;

    logic                    mv1;
    logic                    mv2;
    logic                    adv2;
    logic                    out_free;
    logic                    accept;
    logic                    x_item;
    logic                    x_wr;
    logic                    x_clear;
    logic                    prod_en;
    logic [LEN_W-1:0]        len_eff;
    logic                    emit;
    logic signed [ACC_W-1:0] e_val;
    logic [DEG_W-1:0]        e_deg;
    logic                    e_last;
    t_cell_ctl               ctl;

    logic signed [ACC_W-1:0] w_sum [MAX_TERMS+1];
    logic signed [ACC_W-1:0] w_ps  [MAX_TERMS+1];
    logic [MAX_TERMS-1:0]    load;

    assign w_sum[MAX_TERMS] = '0;
    assign w_ps[MAX_TERMS]  = '0;

    // cell chain
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        assign load[g] = x_wr && (len_eff[IDX_W-1:0] == IDX_W'(g));
        pmul_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_load   (load[g]),
            .i_coef   (r_coef1),
            .i_nb_sum (w_sum[g+1]),
            .i_nb_ps  (w_ps[g+1]),
            .o_sum    (w_sum[g]),
            .o_ps     (w_ps[g])
        );
    end

    assign out_free = !r_ov || !i_stall;
    assign adv2     = !r_v2 || mv2;
    assign mv1      = r_v1 && (!r_closed || adv2);
    assign o_stall  = r_v1 && !mv1;
    assign accept   = i_valid && !o_stall;

    // input stage control
    always_comb begin
        x_item        = mv1 && !r_kind1;
        len_eff       = r_closed ? '0 : r_len;
        x_wr          = x_item && (len_eff < LEN_W'(MAX_TERMS));
        x_clear       = x_item && r_closed;
        prod_en       = mv1 && r_kind1 && r_closed;
        n_len         = r_len;
        n_closed      = r_closed;
        if (x_item) begin
            n_len    = x_wr ? len_eff + LEN_W'(1) : len_eff;
            n_closed = r_last1;
        end
    end

    // accumulate stage and flush sequencer
    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_rem           = r_rem;
        n_deg           = r_deg;
        cnt_after       = r_count;
        mv2             = 1'b0;
        emit            = 1'b0;
        e_val           = w_sum[0];
        e_deg           = r_deg;
        e_last          = 1'b0;
        ctl.x_clear     = x_clear;
        ctl.prod_en     = prod_en;
        ctl.acc_step    = 1'b0;
        ctl.flush_shift = 1'b0;
        ctl.ps_clear    = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (r_v2 && out_free) begin
                    mv2 = 1'b1;
                    case (r_op2)
                        OP_CLEAR: begin
                            ctl.ps_clear = 1'b1;
                            n_count      = '0;
                        end
                        OP_STEP: begin
                            if (r_count < LEN_W'(MAX_TERMS)) begin
                                ctl.acc_step = 1'b1;
                                emit         = 1'b1;
                                e_val        = w_sum[0];
                                e_deg        = DEG_W'(r_count);
                                e_last       = r_last2 && (r_n2 <= LEN_W'(1));
                                cnt_after    = r_count + LEN_W'(1);
                            end
                            n_count = cnt_after;
                            if (r_last2) begin
                                if (r_n2 > LEN_W'(1)) begin
                                    n_state = ST_FLUSH;
                                    n_rem   = r_n2 - LEN_W'(1);
                                    n_deg   = DEG_W'(cnt_after);
                                end else begin
                                    ctl.ps_clear = 1'b1;
                                    n_count      = '0;
                                end
                            end
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit            = 1'b1;
                    e_val           = w_ps[0];
                    e_deg           = r_deg;
                    e_last          = (r_rem == LEN_W'(1));
                    ctl.flush_shift = 1'b1;
                    n_deg           = r_deg + DEG_W'(1);
                    n_rem           = r_rem - LEN_W'(1);
                    if (r_rem == LEN_W'(1)) begin
                        ctl.ps_clear = 1'b1;
                        n_count      = '0;
                        n_state      = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (mv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind1 <= i_kind;
            r_coef1 <= i_coef;
            r_last1 <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_closed <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_closed <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (mv1 && r_closed) begin
            r_v2 <= 1'b1;
        end else if (mv2) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1 && r_closed) begin
            r_op2   <= r_kind1 ? OP_STEP : OP_CLEAR;
            r_last2 <= r_last1;
            r_n2    <= r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_count <= '0;
            r_rem   <= '0;
            r_deg   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rem   <= n_rem;
            r_deg   <= n_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oprod <= e_val;
            r_odeg  <= e_deg;
            r_olast <= e_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_prod_coef = r_oprod;
    assign o_degree    = r_odeg;
    assign o_last_res  = r_olast;

    a_flush_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !mv2)
        else $error("accumulate stage advanced during flush");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(MAX_TERMS))
        else $error("second operand count beyond cell chain");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_TERMS))
        else $error("first operand length beyond cell chain");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_ov || !i_stall))
        else $error("result word overwrote a waiting word");

    a_flush_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_rem != '0))
        else $error("flush with nothing left to emit");

endmodule

`default_nettype wire
